FILE: design/chunk_free_stack_bump_allocator_assert.svh
`ifndef CHUNK_FREE_STACK_BUMP_ALLOCATOR_ASSERT_SVH
`define CHUNK_FREE_STACK_BUMP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define CFSBA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cfsba assertion failed");

// implication checked in the next cycle
`define CFSBA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cfsba assertion failed");

`endif

FILE: design/cfsba_pkg.sv
`default_nettype none

package cfsba_pkg;

    localparam int MAX_CHUNKS  = 1024;
    localparam int CHUNK_SHIFT = 21;
    localparam int IDX_W       = 11;
    localparam int MEM_AW      = $clog2(MAX_CHUNKS);
    localparam int ADDR_W      = 48;
    localparam int CORE_W      = 8;
    localparam int CNT_W       = 11;
    localparam int STAT_W      = 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CNT_W-1:0] CACHED_MAX      = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MAX_CACHED_INIT = CNT_W'(64);
    localparam logic [IDX_W-1:0] LAST_INDEX      = IDX_W'(MAX_CHUNKS);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_FREE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ARENA_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CACHED = 1'd1;

    typedef struct packed {
        logic             command;
        logic [CORE_W-1:0] owner_core;
        logic [IDX_W-1:0] free_index;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  chunk_index;
        logic [ADDR_W-1:0] chunk_address;
        logic [STAT_W-1:0] status;
        logic              purge;
        logic              from_stack;
    } result_t;

endpackage

`default_nettype wire

FILE: design/chunk_free_stack_bump_allocator.sv
`default_nettype none

// a result strobes on done in the cycle after start is taken
// a free, a bump allocation or an exhausted one leaves the block idle for the next item; a
// pop from the stack holds busy in S_POP: the new head comes from the registered link read
// reset: stack empty, bump counter at one, cached count zero, max_cached 64;
// every result is presented on done for one cycle, the receiver cannot stall
module chunk_free_stack_bump_allocator
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire cfsba_pkg::item_t                      item,
    output logic                                       done,
    output cfsba_pkg::result_t                         result,
    input  wire logic                                  cfg_we,
    input  wire logic [cfsba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cfsba_pkg::ADDR_W-1:0]          cfg_data
);

    typedef enum logic {S_IDLE, S_POP} state_t;

    state_t                          state_reg;
    logic [cfsba_pkg::IDX_W-1:0]     head_reg;
    logic [cfsba_pkg::IDX_W-1:0]     bump_reg;
    logic [cfsba_pkg::CNT_W-1:0]     cached_reg;
    logic [cfsba_pkg::ADDR_W-1:0]    base_reg;
    logic [cfsba_pkg::CNT_W-1:0]     max_cached_reg;
    logic                            done_reg;
    cfsba_pkg::result_t              result_reg;

    logic [cfsba_pkg::IDX_W-1:0]     link_mem [cfsba_pkg::MAX_CHUNKS];
    logic [cfsba_pkg::CORE_W-1:0]    owner_mem [cfsba_pkg::MAX_CHUNKS];
    logic [cfsba_pkg::IDX_W-1:0]     link_rdata_reg;

    logic                            accept;
    logic                            is_alloc;
    logic                            stack_nonempty;
    logic                            bump_ok;
    logic                            free_ok;
    logic [cfsba_pkg::IDX_W-1:0]     res_idx;
    logic [cfsba_pkg::IDX_W-1:0]     res_idx_m1;
    logic [cfsba_pkg::IDX_W-1:0]     head_m1;
    logic [cfsba_pkg::ADDR_W-1:0]    res_offset;
    logic                            link_we;
    logic [cfsba_pkg::IDX_W-1:0]     link_wdata;
    logic                            owner_we;
    cfsba_pkg::result_t              result_next;

    assign busy   = (state_reg == S_POP);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        accept         = start && !busy;
        is_alloc       = (item.command == cfsba_pkg::CMD_ALLOC);
        stack_nonempty = (head_reg != '0);
        bump_ok        = (bump_reg <= cfsba_pkg::LAST_INDEX);
        // every nonzero index below the bump counter has been handed out by it once
        free_ok        = (item.free_index != '0) && (item.free_index < bump_reg);

        result_next            = '0;
        result_next.status     = cfsba_pkg::STAT_OK;
        if (is_alloc)
        begin
            priority if (stack_nonempty)
            begin
                result_next.chunk_index = head_reg;
                result_next.from_stack  = 1'b1;
            end
            else if (bump_ok)
            begin
                result_next.chunk_index = bump_reg;
            end
            else
            begin
                result_next.status = cfsba_pkg::STAT_EXHAUSTED;
            end
        end
        else
        begin
            if (free_ok)
            begin
                result_next.chunk_index = item.free_index;
                result_next.purge       = (cached_reg > max_cached_reg);
            end
            else
            begin
                result_next.status = cfsba_pkg::STAT_BAD_FREE;
            end
        end

        res_idx    = result_next.chunk_index;
        res_idx_m1 = res_idx - cfsba_pkg::IDX_W'(1);
        res_offset = cfsba_pkg::ADDR_W'(res_idx_m1) << cfsba_pkg::CHUNK_SHIFT;
        result_next.chunk_address = (res_idx == '0) ? '0 : (base_reg + res_offset);

        head_m1    = head_reg - cfsba_pkg::IDX_W'(1);
        owner_we   = accept && is_alloc && (res_idx != '0);
        link_we    = owner_we || (accept && !is_alloc && free_ok);
        link_wdata = is_alloc ? '0 : head_reg;
    end

    // link memory: push writes the old head at the freed entry, an allocation clears
    // its entry, pop reads at head (old contents on a same-entry write)
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[res_idx_m1[cfsba_pkg::MEM_AW-1:0]] <= link_wdata;
        end
        link_rdata_reg <= link_mem[head_m1[cfsba_pkg::MEM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[res_idx_m1[cfsba_pkg::MEM_AW-1:0]] <= item.owner_core;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            bump_reg       <= cfsba_pkg::IDX_W'(1);
            cached_reg     <= '0;
            base_reg       <= '0;
            max_cached_reg <= cfsba_pkg::MAX_CACHED_INIT;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                result_reg <= result_next;
            end

            if (cfg_we)
            begin
                if (cfg_index == cfsba_pkg::REG_ARENA_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else if (cfg_index == cfsba_pkg::REG_MAX_CACHED)
                begin
                    max_cached_reg <= cfg_data[cfsba_pkg::CNT_W-1:0];
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_alloc)
                        begin
                            priority if (stack_nonempty)
                            begin
                                state_reg <= S_POP;
                                if (cached_reg != '0)
                                begin
                                    cached_reg <= cached_reg - cfsba_pkg::CNT_W'(1);
                                end
                            end
                            else if (bump_ok)
                            begin
                                bump_reg <= bump_reg + cfsba_pkg::IDX_W'(1);
                            end
                            else
                            begin
                                bump_reg <= bump_reg;
                            end
                        end
                        else if (free_ok)
                        begin
                            head_reg <= item.free_index;
                            if (cached_reg != cfsba_pkg::CACHED_MAX)
                            begin
                                cached_reg <= cached_reg + cfsba_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
                S_POP:
                begin
                    // link word from the read issued at accept
                    head_reg  <= (link_rdata_reg > cfsba_pkg::LAST_INDEX) ? '0 : link_rdata_reg;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/cfsba_checker.sv
`default_nettype none

`include "chunk_free_stack_bump_allocator_assert.svh"

module cfsba_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire cfsba_pkg::result_t result
);

    logic accept;
    logic bad_word;
    logic none_word;

    assign accept    = start && !busy;
    assign bad_word  = done && (result.status != cfsba_pkg::STAT_OK);
    assign none_word = done && (result.chunk_index == '0);

    `CFSBA_ASSERT_NEXT(a_word_follows_accept, accept, done)
    `CFSBA_ASSERT_NEXT(a_no_word_without_accept, !accept, !done)
    `CFSBA_ASSERT_NOW(a_fail_has_no_index, bad_word, result.chunk_index == '0)
    `CFSBA_ASSERT_NOW(a_none_has_no_address, none_word, result.chunk_address == '0)

endmodule

bind chunk_free_stack_bump_allocator cfsba_checker u_cfsba_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
